// ===== design/ple_pkg.sv =====
// Package for the positional list engine.
// Holds operation and status codes, sequencer states and shared structs.
// Depends on nothing.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int POS_W = 6;
    localparam int ITEM_W = 32;
    localparam int COUNT_OUT_W = 6;

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_HEAD   = 3'd1,
        FN_AFTER  = 3'd2,
        FN_DELETE = 3'd3,
        FN_SWAP   = 3'd4,
        FN_DUMP   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_DEL_RD,
        S_DEL_GONE,
        S_DEL,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR0,
        S_SW_WR1,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        status_t                  status;
        logic [ITEM_W-1:0]        item;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     last;
    } result_t;

endpackage

// ===== design/ple_store.sv =====
// Entry store of the positional list engine: one write port and one read
// port with registered read data. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_store import ple_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  mem_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ple_ctrl.sv =====
// Sequencer of the positional list engine: decodes an operation, walks the
// entry store to open or close a gap, swap or dump, and produces results.
// Depends on ple_pkg and ple_store.
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_func,
    input  logic [POS_W-1:0]    s_position,
    input  logic signed [31:0]  s_value,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    logic [DATA_WIDTH-1:0] item_reg, item_next;
    status_t               status_reg, status_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;

    mem_ctl_t              mem_ctl;
    logic [AW-1:0]         mem_wr_addr;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [CW+POS_W-1:0]   pos_w;
    logic [CW+POS_W-1:0]   cnt_w;
    logic [CW-1:0]         pos_idx;
    logic                  pos_zero;
    logic                  pos_gt;
    logic                  pos_ge;
    logic                  full;
    logic [DATA_WIDTH+31:0] val_ext;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         ptr_dec;
    logic                  ins_rd;
    logic                  del_rd;
    logic                  dump_last;
    logic [DATA_WIDTH-1:0] out_word;
    logic [DATA_WIDTH+31:0] out_word_w;
    logic [CW+COUNT_OUT_W-1:0] cnt_out_w;

    ple_store #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    assign pos_w     = {{CW{1'b0}}, s_position};
    assign cnt_w     = {{POS_W{1'b0}}, count_reg};
    assign pos_idx   = pos_w[CW-1:0];
    assign pos_zero  = (s_position == '0);
    assign pos_gt    = (pos_w > cnt_w);
    assign pos_ge    = (pos_w >= cnt_w);
    assign full      = (count_reg == CW'(CAPACITY));
    assign val_ext   = {{DATA_WIDTH{s_value[31]}}, s_value};
    assign ptr_inc   = ptr_reg + CW'(1);
    assign ptr_dec   = ptr_reg - CW'(1);
    assign ins_rd    = (ptr_reg > idx_reg);
    assign del_rd    = (ptr_inc < count_reg);
    assign dump_last = (ptr_inc == count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (func_t'(s_func))
                        FN_APPEND, FN_HEAD: state_next = full ? S_RESULT : S_INS;
                        FN_AFTER:  state_next = (pos_zero || pos_gt || full) ? S_RESULT : S_INS;
                        FN_DELETE: state_next = (pos_zero || pos_gt) ? S_RESULT : S_DEL_RD;
                        FN_SWAP:   state_next = (pos_zero || pos_ge) ? S_RESULT : S_SW_RD0;
                        FN_DUMP:   state_next = (count_reg == '0) ? S_RESULT : S_DUMP_RD;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end
            S_INS: begin
                if (!ins_rd && !wr_pend_reg) begin
                    state_next = S_RESULT;
                end
            end
            S_DEL_RD:   state_next = S_DEL_GONE;
            S_DEL_GONE: state_next = S_DEL;
            S_DEL: begin
                if (!del_rd && !wr_pend_reg) begin
                    state_next = S_RESULT;
                end
            end
            S_SW_RD0:  state_next = S_SW_RD1;
            S_SW_RD1:  state_next = S_SW_WR0;
            S_SW_WR0:  state_next = S_SW_WR1;
            S_SW_WR1:  state_next = S_RESULT;
            S_DUMP_RD: state_next = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (res_ready && dump_last) begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mem_ctl     = '0;
        mem_wr_addr = wr_addr_reg;
        mem_wr_data = rd_data;
        mem_rd_addr = ptr_reg[AW-1:0];
        s_ready     = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_INS: begin
                mem_ctl.rd_en = ins_rd;
                mem_rd_addr   = ptr_dec[AW-1:0];
                if (wr_pend_reg) begin
                    mem_ctl.wr_en = 1'b1;
                end else if (!ins_rd) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_wr_addr   = idx_reg[AW-1:0];
                    mem_wr_data   = val_reg;
                end
            end
            S_DEL_RD: begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = idx_reg[AW-1:0];
            end
            S_DEL: begin
                mem_ctl.rd_en = del_rd;
                mem_rd_addr   = ptr_inc[AW-1:0];
                mem_ctl.wr_en = wr_pend_reg;
            end
            S_SW_RD0: begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = idx_reg[AW-1:0];
            end
            S_SW_RD1: begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = ptr_reg[AW-1:0];
            end
            S_SW_WR0: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = idx_reg[AW-1:0];
            end
            S_SW_WR1: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = ptr_reg[AW-1:0];
                mem_wr_data   = tmp_reg;
            end
            S_DUMP_RD: begin
                mem_ctl.rd_en = 1'b1;
            end
            S_DUMP_OUT: begin
                res_valid     = 1'b1;
                mem_ctl.rd_en = res_ready && !dump_last;
                mem_rd_addr   = ptr_inc[AW-1:0];
            end
            S_RESULT: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        val_next     = val_reg;
        tmp_next     = tmp_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        unique case (state_reg)
            S_IDLE: begin
                val_next     = val_ext[DATA_WIDTH-1:0];
                item_next    = '0;
                status_next  = ST_OK;
                wr_pend_next = 1'b0;
                ptr_next     = count_reg;
                idx_next     = count_reg;
                unique case (func_t'(s_func))
                    FN_APPEND: begin
                        if (full) status_next = ST_FULL;
                    end
                    FN_HEAD: begin
                        idx_next = '0;
                        if (full) status_next = ST_FULL;
                    end
                    FN_AFTER: begin
                        idx_next = pos_idx;
                        if (pos_zero || pos_gt) begin
                            status_next = ST_BADPOS;
                        end else if (full) begin
                            status_next = ST_FULL;
                        end
                    end
                    FN_DELETE: begin
                        idx_next = pos_idx - CW'(1);
                        if (pos_zero || pos_gt) status_next = ST_BADPOS;
                    end
                    FN_SWAP: begin
                        idx_next = pos_idx - CW'(1);
                        ptr_next = pos_idx;
                        if (pos_zero || pos_ge) status_next = ST_BADPOS;
                    end
                    FN_DUMP: begin
                        ptr_next = '0;
                        if (count_reg == '0) status_next = ST_EMPTY;
                    end
                    default: ;
                endcase
            end
            S_INS: begin
                if (ins_rd) begin
                    ptr_next     = ptr_dec;
                    wr_pend_next = 1'b1;
                    wr_addr_next = ptr_reg[AW-1:0];
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) count_next = count_reg + CW'(1);
                end
            end
            S_DEL_GONE: begin
                item_next = rd_data;
                ptr_next  = idx_reg;
            end
            S_DEL: begin
                if (del_rd) begin
                    ptr_next     = ptr_inc;
                    wr_pend_next = 1'b1;
                    wr_addr_next = ptr_reg[AW-1:0];
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) count_next = count_reg - CW'(1);
                end
            end
            S_SW_RD1: tmp_next = rd_data;
            S_DUMP_OUT: begin
                if (res_ready && !dump_last) ptr_next = ptr_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        tmp_reg     <= tmp_next;
        item_reg    <= item_next;
        status_reg  <= status_next;
        wr_addr_reg <= wr_addr_next;
    end

    assign out_word   = (state_reg == S_DUMP_OUT) ? rd_data : item_reg;
    assign out_word_w = {32'b0, out_word};
    assign cnt_out_w  = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb begin
        res.status = (state_reg == S_DUMP_OUT) ? ST_OK : status_reg;
        res.item   = out_word_w[ITEM_W-1:0];
        res.count  = cnt_out_w[COUNT_OUT_W-1:0];
        res.last   = (state_reg == S_DUMP_OUT) ? dump_last : 1'b1;
    end

endmodule

// ===== design/positional_list_engine.sv =====
// Positional list engine: bounded ordered list of signed values with
// append, insert at head, insert after position, delete, swap and dump.
// Each transaction on the s_ channel carries one operation. Every operation
// gives one result transaction on the m_ channel; a dump gives one per entry
// in list order, and m_last marks the final result of each operation.
// The block takes one operation at a time; s_ready is high while the
// sequencer is idle, also while a result still waits in the output register.
// The entries live in one store with registered read data, so the time per
// operation is set by the walk through that store, one entry per cycle; a
// dump waits on each entry until its result is taken. An insert moves every
// entry from its index to the end up by one, a delete moves every entry
// behind the deleted one down by one, and a swap reads both entries and
// writes them back crosswise. Each result is held in the output register
// before it appears on m_valid.
// Reset clears the count and the control state; the store contents are not
// cleared and are only read below the count. When m_ready is low the output
// register holds its transaction and the sequencer waits on its next result.
`timescale 1ns / 1ps

module positional_list_engine import ple_pkg::*; #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_func,
    input  logic [POS_W-1:0]          s_position,
    input  logic signed [31:0]        s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [31:0]        m_item_value,
    output logic [COUNT_OUT_W-1:0]    m_entry_count,
    output logic                      m_last
);

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    m_valid_reg, m_valid_next;
    result_t out_reg;

    ple_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_value    (s_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_item_value  = out_reg.item;
    assign m_entry_count = out_reg.count;
    assign m_last        = out_reg.last;

endmodule
